### rtl/rc_switch_click_light_controller_assert.svh
// assertion macros for the click light controller
`ifndef RC_SWITCH_CLICK_LIGHT_CONTROLLER_ASSERT_SVH
`define RC_SWITCH_CLICK_LIGHT_CONTROLLER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RCSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RCSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rcsw_pkg.sv
// shared types and constants for the click light controller
`default_nettype none

package rcsw_pkg;

  localparam int unsigned THR_W   = 12;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned BAR_W   = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned REQ_W   = 2;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 12'd1500;
  localparam logic [TICK_W-1:0] QUIET_RESET     = 16'd750;
  localparam logic [TICK_W-1:0] STARTUP_RESET   = 16'd2000;
  localparam logic [BAR_W-1:0]  BAR_COUNT_RESET = 8'd8;

  // register word index, taken from paddr[3:2]
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_QUIET     = 2'd1;
  localparam logic [1:0] REG_STARTUP   = 2'd2;
  localparam logic [1:0] REG_BAR_COUNT = 2'd3;

  typedef struct packed {
    logic [THR_W-1:0]  level_threshold;
    logic [TICK_W-1:0] quiet_ticks;
    logic [TICK_W-1:0] startup_ticks;
    logic [BAR_W-1:0]  bar_count;
  } cfg_t;

  typedef struct packed {
    logic              chassis_lamp;
    logic              tail_lamp;
    logic              low_beam;
    logic              high_beam;
    logic              string_lamp;
    logic              blink_paused;
    logic [MODE_W-1:0] current_mode;
    logic [BAR_W-1:0]  current_bar;
    logic              reversed;
    logic              alternate_drive;
    logic [REQ_W-1:0]  action_request;
  } status_t;

endpackage

`default_nettype wire

### rtl/rcsw_regs.sv
// apb configuration registers
`default_nettype none

module rcsw_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output rcsw_pkg::cfg_t          cfg
);
  import rcsw_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_threshold <= THRESHOLD_RESET;
      cfg.quiet_ticks     <= QUIET_RESET;
      cfg.startup_ticks   <= STARTUP_RESET;
      cfg.bar_count       <= BAR_COUNT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: cfg.level_threshold <= pwdata[THR_W-1:0];
        REG_QUIET:     cfg.quiet_ticks     <= pwdata[TICK_W-1:0];
        REG_STARTUP:   cfg.startup_ticks   <= pwdata[TICK_W-1:0];
        REG_BAR_COUNT: cfg.bar_count       <= pwdata[BAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = {20'd0, cfg.level_threshold};
      REG_QUIET:     prdata = {16'd0, cfg.quiet_ticks};
      REG_STARTUP:   prdata = {16'd0, cfg.startup_ticks};
      REG_BAR_COUNT: prdata = {24'd0, cfg.bar_count};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/rcsw_click.sv
// level slicer, click counter, quiet timer and start-up blanking
`default_nettype none

module rcsw_click (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic                          command,
  input  wire logic [rcsw_pkg::THR_W-1:0]    pulse_width,
  input  wire rcsw_pkg::cfg_t                cfg,
  output logic      [rcsw_pkg::COUNT_W-1:0]  click_event,
  output logic                               blanking
);
  import rcsw_pkg::*;

  logic               last_level, last_level_next;
  logic [COUNT_W-1:0] edge_count, edge_count_next;
  logic [TICK_W-1:0]  quiet_elapsed, quiet_elapsed_next;
  logic [TICK_W-1:0]  uptime, uptime_next;
  logic               level;
  logic [COUNT_W-1:0] counted;
  logic               dispatch;

  assign level = (pulse_width >= cfg.level_threshold);

  always_comb begin
    last_level_next    = last_level;
    counted            = edge_count;
    quiet_elapsed_next = quiet_elapsed;
    uptime_next        = uptime;
    if (command) begin
      // millisecond tick, both timers saturate
      if (uptime != '1) uptime_next = uptime + 1'b1;
      if (quiet_elapsed != '1) quiet_elapsed_next = quiet_elapsed + 1'b1;
    end else begin
      if (level != last_level) begin
        quiet_elapsed_next = '0;
        if (edge_count != '1) counted = edge_count + 1'b1;
      end
      last_level_next = level;
    end
    blanking = (uptime_next <= cfg.startup_ticks);
    if (blanking) counted = '0;
    dispatch        = (quiet_elapsed_next >= cfg.quiet_ticks) && (counted != '0);
    click_event     = dispatch ? counted : '0;
    edge_count_next = dispatch ? '0 : counted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b1;
      edge_count    <= '0;
      quiet_elapsed <= '0;
      uptime        <= '0;
    end else if (fire) begin
      last_level    <= last_level_next;
      edge_count    <= edge_count_next;
      quiet_elapsed <= quiet_elapsed_next;
      uptime        <= uptime_next;
    end
  end

endmodule

`default_nettype wire

### rtl/rcsw_cmd.sv
// click command decoder, lamp and mode state
`default_nettype none

module rcsw_cmd (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic [rcsw_pkg::COUNT_W-1:0]  click_event,
  input  wire logic [rcsw_pkg::BAR_W-1:0]    bar_count,
  output rcsw_pkg::status_t                  status
);
  import rcsw_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_LED_SELECT = 2'd1,
    MODE_CALIBRATE  = 2'd2
  } mode_t;

  localparam logic [COUNT_W-1:0] CLICK_LIGHT   = 8'd1;
  localparam logic [COUNT_W-1:0] CLICK_BEAM    = 8'd2;
  localparam logic [COUNT_W-1:0] CLICK_BLINK   = 8'd3;
  localparam logic [COUNT_W-1:0] CLICK_SELECT  = 8'd4;
  localparam logic [COUNT_W-1:0] CLICK_CALIB   = 8'd6;
  localparam logic [COUNT_W-1:0] CLICK_DRIVE   = 8'd7;
  localparam logic [COUNT_W-1:0] CLICK_REVERSE = 8'd9;

  localparam logic [REQ_W-1:0] REQ_NONE    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAVE    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REBOOT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DISPLAY = 2'd3;

  mode_t            mode, mode_next;
  logic [1:0]       light_step, light_step_next;
  logic             beam, beam_next;
  logic             blink_stop, blink_stop_next;
  logic [BAR_W-1:0] bar, bar_next, bar_inc;
  logic             dir, dir_next;
  logic             drive, drive_next;
  logic             chassis, chassis_next;
  logic             tail, tail_next;
  logic             low, low_next;
  logic             high, high_next;
  logic             strng, strng_next;
  logic [REQ_W-1:0] req;

  assign bar_inc = bar + 1'b1;

  always_comb begin
    mode_next       = mode;
    light_step_next = light_step;
    beam_next       = beam;
    blink_stop_next = blink_stop;
    bar_next        = bar;
    dir_next        = dir;
    drive_next      = drive;
    chassis_next    = chassis;
    tail_next       = tail;
    low_next        = low;
    high_next       = high;
    strng_next      = strng;
    req             = REQ_NONE;
    case (click_event)
      CLICK_LIGHT: begin
        if (mode == MODE_LED_SELECT) begin
          bar_next = (bar_inc >= bar_count) ? '0 : bar_inc;
          req      = REQ_DISPLAY;
        end else begin
          light_step_next = light_step + 1'b1;
          chassis_next    = (light_step_next != 2'd0);
          tail_next       = (light_step_next != 2'd0);
          if (light_step_next == 2'd2) low_next = 1'b1;
          else if (light_step_next == 2'd3) low_next = 1'b0;
        end
      end
      CLICK_BEAM: begin
        beam_next = !beam;
        high_next = beam_next;
        low_next  = beam_next || (light_step == 2'd2);
      end
      CLICK_BLINK: begin
        if (blink_stop) begin
          chassis_next    = (light_step != 2'd0);
          blink_stop_next = 1'b0;
        end else begin
          blink_stop_next = 1'b1;
        end
      end
      CLICK_SELECT: begin
        if (mode == MODE_NORMAL) begin
          mode_next = MODE_LED_SELECT;
          req       = REQ_DISPLAY;
        end else if (mode == MODE_LED_SELECT) begin
          mode_next = MODE_NORMAL;
          req       = REQ_SAVE;
        end
      end
      CLICK_CALIB: begin
        if (mode == MODE_NORMAL) mode_next = MODE_CALIBRATE;
      end
      CLICK_DRIVE: begin
        drive_next = !drive;
        strng_next = drive_next;
        req        = REQ_SAVE;
      end
      CLICK_REVERSE: begin
        dir_next = !dir;
        req      = REQ_REBOOT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      light_step <= '0;
      beam       <= 1'b0;
      blink_stop <= 1'b0;
      bar        <= '0;
      dir        <= 1'b0;
      drive      <= 1'b0;
      chassis    <= 1'b0;
      tail       <= 1'b0;
      low        <= 1'b0;
      high       <= 1'b0;
      strng      <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      light_step <= light_step_next;
      beam       <= beam_next;
      blink_stop <= blink_stop_next;
      bar        <= bar_next;
      dir        <= dir_next;
      drive      <= drive_next;
      chassis    <= chassis_next;
      tail       <= tail_next;
      low        <= low_next;
      high       <= high_next;
      strng      <= strng_next;
    end
  end

  // status after this word's command
  always_comb begin
    status.chassis_lamp    = chassis_next;
    status.tail_lamp       = tail_next;
    status.low_beam        = low_next;
    status.high_beam       = high_next;
    status.string_lamp     = strng_next;
    status.blink_paused    = blink_stop_next;
    status.current_mode    = mode_next;
    status.current_bar     = bar_next;
    status.reversed        = dir_next;
    status.alternate_drive = drive_next;
    status.action_request  = req;
  end

endmodule

`default_nettype wire

### rtl/rc_switch_click_light_controller.sv
// top level of the radio-control switch click light controller
//
// input stream: one word per pulse width sample or millisecond tick.
//   s_axis_tuser selects the kind (0 sample, 1 tick), s_axis_tdata[11:0]
//   carries the pulse width in microseconds.
// output stream: one status word per input word, with the dispatched click
//   count (0 when none), lamp levels, mode, bar index, flags and request.
// configuration: apb port with four word registers (threshold, quiet time,
//   start-up blanking time, bar count); the user must see that they are
//   written only while the block is idle; the block does not enforce it.
// path: an accepted word sits in the input register; the per-word state
//   update (counter, timers, command decode) is combinational logic between
//   the two registers, and its status word is loaded into the output
//   register when free (empty or m_axis_tready high); m_axis_tvalid rises.
// throughput: one word per cycle while the output stage is not stalled.
// reset: synchronous, clears both stream stages and returns all state to
//   lamps off, normal mode, level high; registers return to their defaults.
// stall: while m_axis_tready is low the output word holds, the input
//   register still takes one more word if empty, then s_axis_tready drops.
`default_nettype none

module rc_switch_click_light_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [11:0] pulse_width, [15:12] zero
  input  wire logic        s_axis_tuser,  // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] click_event, [8] chassis_lamp, [9] tail_lamp, [10] low_beam,
  // [11] high_beam, [12] string_lamp, [13] blink_paused, [15:14] current_mode,
  // [23:16] current_bar, [24] reversed, [25] alternate_drive,
  // [27:26] action_request, [31:28] zero
  output logic [31:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rcsw_pkg::*;

  cfg_t               cfg;
  status_t            status;
  logic [COUNT_W-1:0] click_event;
  logic               blanking;

  // input stage
  logic             in_valid;
  logic             in_command;
  logic [THR_W-1:0] in_pulse;

  // output stage
  logic        out_valid;
  logic [31:0] out_data;

  logic advance;  // output register free to load
  logic fire;     // input word is processed this cycle

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign fire          = in_valid && advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_command <= s_axis_tuser;
      in_pulse   <= s_axis_tdata[THR_W-1:0];
    end
    if (fire) begin
      out_data <= {4'd0, status.action_request, status.alternate_drive,
                   status.reversed, status.current_bar, status.current_mode,
                   status.blink_paused, status.string_lamp, status.high_beam,
                   status.low_beam, status.tail_lamp, status.chassis_lamp,
                   click_event};
    end
  end

  rcsw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // level slicing, click counting, quiet timer, start-up blanking
  rcsw_click u_click (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .command     (in_command),
    .pulse_width (in_pulse),
    .cfg         (cfg),
    .click_event (click_event),
    .blanking    (blanking)
  );

  // dispatched counts drive lamps, mode and requests
  rcsw_cmd u_cmd (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .click_event (click_event),
    .bar_count   (cfg.bar_count),
    .status      (status)
  );

`include "rc_switch_click_light_controller_assert.svh"

  // no click can be dispatched inside the blanking window
`RCSW_ASSERT_NOW(a_no_click_in_blanking, fire && blanking, click_event == '0, "click dispatched while blanking")

  // only light, select, drive and reverse commands raise a request
`RCSW_ASSERT_NOW(a_req_has_click, m_axis_tvalid && (m_axis_tdata[27:26] != 2'd0), (m_axis_tdata[7:0] == 8'd1) || (m_axis_tdata[7:0] == 8'd4) || (m_axis_tdata[7:0] == 8'd7) || (m_axis_tdata[7:0] == 8'd9), "request without matching click")

  // an empty output stage never holds off the input side
`RCSW_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // a processed word always shows up in the output stage
`RCSW_ASSERT_NEXT(a_fire_loads_out, fire, m_axis_tvalid, "processed word lost")

endmodule

`default_nettype wire

### sim/testbench.sv
// self-checking testbench for the click light controller: directed rows, then random phases
`timescale 1ns / 1ps

module testbench;
  import rcsw_pkg::*;

  // input word kinds carried on s_axis_tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // click counts that do something
  localparam logic [COUNT_W-1:0] CLICK_LIGHT      = 8'd1;
  localparam logic [COUNT_W-1:0] CLICK_BEAM       = 8'd2;
  localparam logic [COUNT_W-1:0] CLICK_BLINK      = 8'd3;
  localparam logic [COUNT_W-1:0] CLICK_LED_SELECT = 8'd4;
  localparam logic [COUNT_W-1:0] CLICK_CALIBRATE  = 8'd6;
  localparam logic [COUNT_W-1:0] CLICK_DRIVE_MODE = 8'd7;
  localparam logic [COUNT_W-1:0] CLICK_DIRECTION  = 8'd9;

  // cycles with no word, no status and no register access before giving up
  localparam int STALL_LIMIT = 3000;
  // cap on printed mismatch lines, all of them are still counted
  localparam int PRINT_CAP = 50;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL, MODE_LED_SELECT, MODE_CALIBRATION
  } mode_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE, REQ_SAVE, REQ_SAVE_REBOOT, REQ_DISPLAY
  } request_e;

  // status word layout, msb first, matching m_axis_tdata
  typedef struct packed {
    logic [3:0]        spare;
    logic [REQ_W-1:0]  action_request;
    logic              alternate_drive;
    logic              reversed;
    logic [BAR_W-1:0]  current_bar;
    logic [MODE_W-1:0] current_mode;
    logic              blink_paused;
    logic              string_lamp;
    logic              high_beam;
    logic              low_beam;
    logic              tail_lamp;
    logic              chassis_lamp;
    logic [COUNT_W-1:0] click_event;
  } status_word_t;

  typedef enum { ROW_WORD, ROW_FIXED, ROW_REG } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    logic         cmd;
    logic [11:0]  width;
    logic [1:0]   reg_idx;
    logic [31:0]  value;
    status_word_t fixed_word;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // dut signals, every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [11:0] pulse_width, [15:12] zero
  logic        s_axis_tuser = 1'b0; // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // click_event, lamps, mode, bar, flags, request
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rc_switch_click_light_controller dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // controller prediction: own copy of registers and state
  // ---------------------------------------------------------------------------
  cfg_t        ctl_cfg = '{THRESHOLD_RESET, QUIET_RESET, STARTUP_RESET, BAR_COUNT_RESET};
  logic        lvl_last = 1'b1;
  logic [7:0]  clicks_held = '0;
  logic [15:0] quiet_ms = '0;
  logic [15:0] uptime_ms = '0;
  logic [1:0]  light_phase = '0;
  logic        beam_on = 1'b0;
  logic        blink_held = 1'b0;
  mode_e       mode = MODE_NORMAL;
  logic [7:0]  bar_idx = '0;
  logic        reversed_dir = 1'b0;
  logic        alt_drive = 1'b0;
  logic        lamp_chassis = 1'b0;
  logic        lamp_tail = 1'b0;
  logic        lamp_low = 1'b0;
  logic        lamp_high = 1'b0;
  logic        lamp_string = 1'b0;

  status_word_t status_due[$];   // predicted status words, oldest first
  int words_sent = 0;
  int words_checked = 0;
  int mismatches = 0;

  // stall settings, read by the sender task and the status receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;

  task automatic step_controller(input logic cmd, input logic [11:0] pw,
                                 output status_word_t word);
    logic             lvl;
    logic [7:0]       fired;
    logic [7:0]       next_bar;
    request_e         req;
    fired = '0;
    req = REQ_NONE;
    if (cmd == CMD_TICK) begin
      if (uptime_ms != 16'hFFFF) uptime_ms++;
      if (quiet_ms != 16'hFFFF) quiet_ms++;
    end else begin
      lvl = (pw >= ctl_cfg.level_threshold);
      // any level flip is a click and restarts the quiet window
      if (lvl != lvl_last) begin
        quiet_ms = '0;
        if (clicks_held != 8'hFF) clicks_held++;
      end
      lvl_last = lvl;
    end
    // start-up blanking throws clicks away
    if (uptime_ms <= ctl_cfg.startup_ticks) clicks_held = '0;
    if (quiet_ms >= ctl_cfg.quiet_ticks && clicks_held != 0) begin
      fired = clicks_held;
      clicks_held = '0;
      case (fired)
        CLICK_LIGHT: begin
          if (mode == MODE_LED_SELECT) begin
            next_bar = bar_idx + 8'd1;
            bar_idx = (next_bar >= ctl_cfg.bar_count) ? 8'd0 : next_bar;
            req = REQ_DISPLAY;
          end else begin
            light_phase = light_phase + 2'd1;
            lamp_chassis = (light_phase != 0);
            lamp_tail = (light_phase != 0);
            if (light_phase == 2'd2) lamp_low = 1'b1;
            else if (light_phase == 2'd3) lamp_low = 1'b0;
          end
        end
        CLICK_BEAM: begin
          beam_on = ~beam_on;
          lamp_high = beam_on;
          lamp_low = beam_on || (light_phase == 2'd2);
        end
        CLICK_BLINK: begin
          if (blink_held) begin
            lamp_chassis = (light_phase != 0);
            blink_held = 1'b0;
          end else begin
            blink_held = 1'b1;
          end
        end
        CLICK_LED_SELECT: begin
          if (mode == MODE_NORMAL) begin
            mode = MODE_LED_SELECT;
            req = REQ_DISPLAY;
          end else if (mode == MODE_LED_SELECT) begin
            mode = MODE_NORMAL;
            req = REQ_SAVE;
          end
        end
        CLICK_CALIBRATE: begin
          if (mode == MODE_NORMAL) mode = MODE_CALIBRATION;
        end
        CLICK_DRIVE_MODE: begin
          alt_drive = ~alt_drive;
          lamp_string = alt_drive;
          req = REQ_SAVE;
        end
        CLICK_DIRECTION: begin
          reversed_dir = ~reversed_dir;
          req = REQ_SAVE_REBOOT;
        end
        default: ;
      endcase
    end
    word = '0;
    word.click_event = fired;
    word.chassis_lamp = lamp_chassis;
    word.tail_lamp = lamp_tail;
    word.low_beam = lamp_low;
    word.high_beam = lamp_high;
    word.string_lamp = lamp_string;
    word.blink_paused = blink_held;
    word.current_mode = mode;
    word.current_bar = bar_idx;
    word.reversed = reversed_dir;
    word.alternate_drive = alt_drive;
    word.action_request = req;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at status word %0d: %s got %0d, predicted %0d",
               words_checked, what, got, want);
    mismatches++;
  endtask

  task automatic check_status(input status_word_t got);
    status_word_t want;
    if (status_due.size() == 0) begin
      report_mismatch("unexpected word", got, 0);
      return;
    end
    want = status_due.pop_front();
    if (got.click_event !== want.click_event)
      report_mismatch("click_event", got.click_event, want.click_event);
    if (got.chassis_lamp !== want.chassis_lamp)
      report_mismatch("chassis_lamp", got.chassis_lamp, want.chassis_lamp);
    if (got.tail_lamp !== want.tail_lamp)
      report_mismatch("tail_lamp", got.tail_lamp, want.tail_lamp);
    if (got.low_beam !== want.low_beam)
      report_mismatch("low_beam", got.low_beam, want.low_beam);
    if (got.high_beam !== want.high_beam)
      report_mismatch("high_beam", got.high_beam, want.high_beam);
    if (got.string_lamp !== want.string_lamp)
      report_mismatch("string_lamp", got.string_lamp, want.string_lamp);
    if (got.blink_paused !== want.blink_paused)
      report_mismatch("blink_paused", got.blink_paused, want.blink_paused);
    if (got.current_mode !== want.current_mode)
      report_mismatch("current_mode", got.current_mode, want.current_mode);
    if (got.current_bar !== want.current_bar)
      report_mismatch("current_bar", got.current_bar, want.current_bar);
    if (got.reversed !== want.reversed)
      report_mismatch("reversed", got.reversed, want.reversed);
    if (got.alternate_drive !== want.alternate_drive)
      report_mismatch("alternate_drive", got.alternate_drive, want.alternate_drive);
    if (got.action_request !== want.action_request)
      report_mismatch("action_request", got.action_request, want.action_request);
    if (got.spare !== want.spare)
      report_mismatch("spare bits", got.spare, want.spare);
    words_checked++;
  endtask

  // status receiver: samples at the edge, then picks the next tready
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) check_status(m_axis_tdata);
      // long hold-off asked by the stimulus, counted here
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || psel || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one word, predict its status once it is taken
  task automatic send_word(input logic cmd, input logic [11:0] pw,
                           input bit use_fixed, input status_word_t fixed_word);
    status_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'b0, pw};
    do @(posedge clk); while (!s_axis_tready);
    step_controller(cmd, pw, predicted);
    status_due.push_back(use_fixed ? fixed_word : predicted);
    words_sent++;
  endtask

  // sender goes quiet until every predicted status word has come back
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // optional write, then read back and compare with the predicted register
  task automatic access_register(input logic [1:0] idx, input bit do_write,
                                 input logic [31:0] data);
    logic [31:0] want;
    if (do_write) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      case (idx)
        REG_THRESHOLD: ctl_cfg.level_threshold = data[THR_W-1:0];
        REG_QUIET:     ctl_cfg.quiet_ticks = data[TICK_W-1:0];
        REG_STARTUP:   ctl_cfg.startup_ticks = data[TICK_W-1:0];
        default:       ctl_cfg.bar_count = data[BAR_W-1:0];
      endcase
    end
    // read transfer follows the write back to back
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: want = 32'(ctl_cfg.level_threshold);
      REG_QUIET:     want = 32'(ctl_cfg.quiet_ticks);
      REG_STARTUP:   want = 32'(ctl_cfg.startup_ticks);
      default:       want = 32'(ctl_cfg.bar_count);
    endcase
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // a pulse width on the wanted side of the threshold, sometimes right on it
  function automatic logic [11:0] width_for(input logic high);
    int thr;
    thr = ctl_cfg.level_threshold;
    if (high) begin
      if ($urandom_range(7) == 0) return 12'(thr);
      return 12'($urandom_range(4095, thr));
    end
    if (thr == 0) return 12'd0;  // no low level exists
    if ($urandom_range(7) == 0) return 12'(thr - 1);
    return 12'($urandom_range(thr - 1, 0));
  endfunction

  // a well formed click burst: flips with same-level samples and single ticks
  // mixed in, closed by enough ticks to reach the quiet time
  task automatic send_clicks(input int clicks);
    int k;
    for (k = 0; k < clicks; k++) begin
      if ($urandom_range(7) == 0)
        send_word(CMD_SAMPLE, width_for(lvl_last), 1'b0, '0);
      if ($urandom_range(5) == 0 && int'(quiet_ms) + 1 < int'(ctl_cfg.quiet_ticks))
        send_word(CMD_TICK, 12'($urandom_range(4095)), 1'b0, '0);
      send_word(CMD_SAMPLE, width_for(~lvl_last), 1'b0, '0);
    end
    repeat (int'(ctl_cfg.quiet_ticks) + $urandom_range(2))
      send_word(CMD_TICK, 12'($urandom_range(4095)), 1'b0, '0);
  endtask

  stim_row_t stim_rows[$];

  task automatic add_row(input row_kind_e kind, input logic cmd, input logic [11:0] w,
                         input logic [1:0] idx, input logic [31:0] value);
    stim_row_t row;
    row.kind = kind;
    row.cmd = cmd;
    row.width = w;
    row.reg_idx = idx;
    row.value = value;
    row.fixed_word = '0;   // every typed-in status here is the all-off word
    stim_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph;
    int seq;
    int r;
    int clicks;
    int base;
    int k;
    logic [31:0] cfg_vals [4];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers come out of reset at their defaults
    for (k = 0; k < 4; k++) access_register(2'(k), 1'b0, '0);

    // directed rows; blanking holds every status at all-off until the
    // start-up window is shortened
    add_row(ROW_FIXED, CMD_SAMPLE, 12'd0,    REG_THRESHOLD, '0);
    add_row(ROW_FIXED, CMD_SAMPLE, 12'd4095, REG_THRESHOLD, '0);
    add_row(ROW_FIXED, CMD_SAMPLE, 12'd1499, REG_THRESHOLD, '0);
    add_row(ROW_FIXED, CMD_SAMPLE, 12'd1500, REG_THRESHOLD, '0);
    add_row(ROW_FIXED, CMD_TICK,   12'd0,    REG_THRESHOLD, '0);
    // blanking off, zero quiet time: every flip dispatches at once
    add_row(ROW_REG, CMD_SAMPLE, '0, REG_STARTUP, 32'd0);
    add_row(ROW_REG, CMD_SAMPLE, '0, REG_QUIET, 32'd0);
    add_row(ROW_WORD, CMD_SAMPLE, 12'd1499, REG_THRESHOLD, '0);
    add_row(ROW_WORD, CMD_SAMPLE, 12'd1500, REG_THRESHOLD, '0);
    // threshold extremes
    add_row(ROW_REG, CMD_SAMPLE, '0, REG_THRESHOLD, 32'd0);
    add_row(ROW_WORD, CMD_SAMPLE, 12'd0, REG_THRESHOLD, '0);
    add_row(ROW_REG, CMD_SAMPLE, '0, REG_THRESHOLD, 32'd4095);
    add_row(ROW_WORD, CMD_SAMPLE, 12'd4094, REG_THRESHOLD, '0);
    add_row(ROW_WORD, CMD_SAMPLE, 12'd4095, REG_THRESHOLD, '0);
    // one quiet tick: two clicks, three clicks, four clicks
    add_row(ROW_REG, CMD_SAMPLE, '0, REG_QUIET, 32'd1);
    for (k = 0; k < 2; k++) add_row(ROW_WORD, CMD_SAMPLE, k[0] ? 12'd4095 : 12'd0,
                                    REG_THRESHOLD, '0);
    add_row(ROW_WORD, CMD_TICK, 12'd0, REG_THRESHOLD, '0);
    for (k = 0; k < 3; k++) add_row(ROW_WORD, CMD_SAMPLE, k[0] ? 12'd4095 : 12'd0,
                                    REG_THRESHOLD, '0);
    add_row(ROW_WORD, CMD_TICK, 12'd0, REG_THRESHOLD, '0);
    for (k = 0; k < 4; k++) add_row(ROW_WORD, CMD_SAMPLE, k[0] ? 12'd0 : 12'd4095,
                                    REG_THRESHOLD, '0);
    add_row(ROW_WORD, CMD_TICK, 12'd0, REG_THRESHOLD, '0);
    // led select with zero bar count, then the widest bar count
    add_row(ROW_REG, CMD_SAMPLE, '0, REG_BAR_COUNT, 32'd0);
    add_row(ROW_WORD, CMD_SAMPLE, 12'd4095, REG_THRESHOLD, '0);
    add_row(ROW_WORD, CMD_TICK, 12'd0, REG_THRESHOLD, '0);
    add_row(ROW_REG, CMD_SAMPLE, '0, REG_BAR_COUNT, 32'd255);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        wait_until_idle();
        access_register(stim_rows[i].reg_idx, 1'b1, stim_rows[i].value);
      end else begin
        send_word(stim_rows[i].cmd, stim_rows[i].width,
                  stim_rows[i].kind == ROW_FIXED, stim_rows[i].fixed_word);
      end
    end

    // random phases, each with its own register setting and one of four stall patterns;
    // calibration is a dead end, so six clicks only come in the last phase
    for (ph = 0; ph < 8; ph++) begin
      wait_until_idle();

      if (ph == 7) begin
        // blanking that never ends: start-up window at its top value
        send_idle_pct = 0;
        recv_stall_pct = 0;
        access_register(REG_STARTUP, 1'b1, 32'd65535);
        access_register(REG_QUIET, 1'b1, 32'd1);
        for (k = 0; k < 40; k++) begin
          if ($urandom_range(2) == 0)
            send_word(CMD_TICK, 12'($urandom_range(4095)), 1'b0, '0);
          else
            send_word(CMD_SAMPLE, 12'($urandom_range(4095)), 1'b0, '0);
        end
        wait_until_idle();
      end

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase

      cfg_vals[REG_THRESHOLD] = $urandom_range(4095, 1);
      cfg_vals[REG_QUIET] = $urandom_range(5, 1);
      cfg_vals[REG_STARTUP] = ($urandom_range(1) == 0) ? 0 :
                              int'(uptime_ms) + $urandom_range(20);
      cfg_vals[REG_BAR_COUNT] = $urandom_range(20);
      case (ph)
        0: begin
          cfg_vals[REG_THRESHOLD] = 1500;
          cfg_vals[REG_QUIET] = 3;
          cfg_vals[REG_STARTUP] = 0;
          cfg_vals[REG_BAR_COUNT] = 8;
        end
        1: begin
          // blanking window still open for the first few ticks
          cfg_vals[REG_STARTUP] = int'(uptime_ms) + 10;
          cfg_vals[REG_BAR_COUNT] = 255;
        end
        2: begin
          cfg_vals[REG_THRESHOLD] = 1;
          cfg_vals[REG_QUIET] = 0;
          cfg_vals[REG_BAR_COUNT] = 1;
        end
        3: begin
          cfg_vals[REG_THRESHOLD] = 4095;
          cfg_vals[REG_QUIET] = 2;
          cfg_vals[REG_BAR_COUNT] = 0;
        end
        4: begin
          cfg_vals[REG_QUIET] = 40;
          cfg_vals[REG_STARTUP] = 0;
          cfg_vals[REG_BAR_COUNT] = $urandom_range(255, 1);
        end
        default: ;
      endcase
      for (k = 0; k < 4; k++) access_register(2'(k), 1'b1, cfg_vals[k]);

      base = words_sent;
      seq = 0;
      while (words_sent - base < 190) begin
        // receiver holds off long enough for the block to back up
        if (ph == 4 && seq == 2) hold_request = 300;
        // sender waits for every outstanding status word
        if (ph == 2 && seq == 15) wait_until_idle();
        r = $urandom_range(99);
        if (ph == 0 && seq == 0) clicks = 260;   // runs the count into saturation
        else if (r < 28) clicks = CLICK_LIGHT;
        else if (r < 42) clicks = CLICK_BEAM;
        else if (r < 52) clicks = CLICK_BLINK;
        else if (r < 62) clicks = CLICK_LED_SELECT;
        else if (r < 70) clicks = CLICK_DRIVE_MODE;
        else if (r < 78) clicks = CLICK_DIRECTION;
        else if (r < 84) clicks = $urandom_range(20, 10);
        else if (r < 88) clicks = 5;
        else if (r < 91) clicks = 8;
        else if (r < 95) clicks = (ph == 7) ? CLICK_CALIBRATE : CLICK_LIGHT;
        else clicks = 0;
        if (clicks == 0) begin
          // noise: any kind, any width, no structure
          repeat ($urandom_range(8, 1))
            send_word(1'($urandom_range(1)), 12'($urandom_range(4095)), 1'b0, '0);
        end else begin
          send_clicks(clicks);
        end
        seq++;
      end
    end

    wait_until_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
